[hw/rtl/mbe_pkg.sv]
package mbe_pkg;

   localparam int COORD_WIDTH = 12;
   localparam int FRACTION_BITS = 40;
   localparam int VAL_WIDTH = 48;
   localparam int STEP_WIDTH = 41;
   localparam int COUNT_WIDTH = 16;
   localparam int PROD_WIDTH = COORD_WIDTH + STEP_WIDTH;

   localparam logic signed [VAL_WIDTH-1:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [VAL_WIDTH-1:0] VAL_MIN = 48'sh8000_0000_0000;
   localparam logic [VAL_WIDTH:0] FOUR = 49'(64'd4 << FRACTION_BITS);

   localparam logic [VAL_WIDTH-1:0] RESET_ORIGIN_X = 48'(-64'sd817700076262);
   localparam logic [VAL_WIDTH-1:0] RESET_ORIGIN_Y = 48'd144889138709;
   localparam logic [STEP_WIDTH-1:0] RESET_PIXEL_STEP = 41'd107374;
   localparam logic [COUNT_WIDTH-1:0] RESET_MAX_ITERATIONS = 16'd2000;

   localparam logic [1:0] REG_ORIGIN_X = 2'd0;
   localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
   localparam logic [1:0] REG_PIXEL_STEP = 2'd2;
   localparam logic [1:0] REG_MAX_ITERATIONS = 2'd3;

   typedef struct packed {
      logic signed [VAL_WIDTH-1:0] origin_x;
      logic signed [VAL_WIDTH-1:0] origin_y;
      logic [STEP_WIDTH-1:0] pixel_step;
      logic [COUNT_WIDTH-1:0] max_iterations;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic hold;
      logic [1:0] tag;
      logic [COUNT_WIDTH-1:0] count;
   } ctl_type;

   typedef struct packed {
      logic signed [VAL_WIDTH-1:0] cx;
      logic signed [VAL_WIDTH-1:0] cy;
      logic [VAL_WIDTH-1:0] x2;
      logic [VAL_WIDTH-1:0] y2;
      logic [VAL_WIDTH-1:0] w;
   } pay_type;

   function automatic logic signed [VAL_WIDTH-1:0] sat48(input logic signed [55:0] v);
      logic signed [VAL_WIDTH-1:0] r;
      if (v > 56'(VAL_MAX)) begin
         r = VAL_MAX;
      end else if (v < 56'(VAL_MIN)) begin
         r = VAL_MIN;
      end else begin
         r = v[VAL_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic logic [VAL_WIDTH-1:0] mag48(input logic signed [VAL_WIDTH-1:0] s);
      logic [VAL_WIDTH-1:0] r;
      r = s[VAL_WIDTH-1] ? (~s + 48'd1) : s;
      return r;
   endfunction

endpackage

[hw/rtl/mandelbrot_escape_time_pixel.sv]
// Coordinate setup registers the scaled column and row, then adds the origin; each
// pixel then circulates in the iteration ring, and its count enters the result register.
// The 4-stage iteration ring holds up to four pixels at once, so a new pixel can enter
// before earlier ones finish; results leave in input order. Reset is synchronous and
// active high; it empties the pipeline and restores the default window, step and
// iteration limit.
module mandelbrot_escape_time_pixel (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [11:0] req_column,
   input  logic [11:0] req_row,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [15:0] rsp_iteration_count,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [4:0] csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready
);

   localparam int VW = mbe_pkg::VAL_WIDTH;

   mbe_pkg::cfg_type cfg;
   logic b_valid, b_take;
   logic signed [VW-1:0] b_cx, b_cy;

   mbe_pkg::ctl_type s0_ctl_ff, s0_ctl_in, s1_ctl_ff, s2_ctl_ff, h_ctl_ff;
   mbe_pkg::pay_type s0_pay_ff, s0_pay_in, s1_pay_ff, s2_pay_ff, h_pay_ff, h_pay_in;
   mbe_pkg::pay_type src;
   logic signed [VW-1:0] s0_x_ff, s0_y_ff, s0_x_in, s0_y_in, z;
   logic [VW-1:0] mx_ff, my_ff, mz_ff, sq_x, sq_y, sq_w;
   logic [VW:0] sum;
   logic done, emit, free;
   logic out_valid_ff;
   logic [15:0] out_count_ff;
   logic [1:0] issue_tag_ff, retire_tag_ff;

   mbe_csr u_csr (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready), .cfg(cfg)
   );

   mbe_coord u_coord (
      .clock(clock), .reset(reset), .cfg(cfg),
      .in_valid(req_valid), .in_ready(req_ready),
      .in_column(req_column[mbe_pkg::COORD_WIDTH-1:0]),
      .in_row(req_row[mbe_pkg::COORD_WIDTH-1:0]),
      .out_valid(b_valid), .out_take(b_take), .out_cx(b_cx), .out_cy(b_cy)
   );

   mbe_square u_sq_x (.clock(clock), .mag(mx_ff), .sq(sq_x));
   mbe_square u_sq_y (.clock(clock), .mag(my_ff), .sq(sq_y));
   mbe_square u_sq_w (.clock(clock), .mag(mz_ff), .sq(sq_w));

   always_comb begin
      sum = {1'b0, h_pay_ff.x2} + {1'b0, h_pay_ff.y2};
      done = h_ctl_ff.valid && (sum > mbe_pkg::FOUR || h_ctl_ff.count >= cfg.max_iterations);
      emit = done && (h_ctl_ff.tag == retire_tag_ff) && (!out_valid_ff || rsp_ready);
      free = !h_ctl_ff.valid || emit;
      b_take = free && b_valid;

      if (b_take) begin
         src.cx = b_cx;
         src.cy = b_cy;
         src.x2 = '0;
         src.y2 = '0;
         src.w = '0;
         s0_ctl_in.valid = 1'b1;
         s0_ctl_in.hold = 1'b1;
         s0_ctl_in.tag = issue_tag_ff;
         s0_ctl_in.count = '0;
      end else begin
         src = h_pay_ff;
         s0_ctl_in.valid = h_ctl_ff.valid && !emit;
         s0_ctl_in.hold = done;
         s0_ctl_in.tag = h_ctl_ff.tag;
         s0_ctl_in.count = done ? h_ctl_ff.count : h_ctl_ff.count + 16'd1;
      end
      s0_pay_in = src;
      s0_x_in = mbe_pkg::sat48($signed(56'(src.x2)) - $signed(56'(src.y2)) + 56'(src.cx));
      s0_y_in = mbe_pkg::sat48($signed(56'(src.w)) - $signed(56'(src.x2))
                               - $signed(56'(src.y2)) + 56'(src.cy));
      z = mbe_pkg::sat48(56'(s0_x_ff) + 56'(s0_y_ff));

      h_pay_in.cx = s2_pay_ff.cx;
      h_pay_in.cy = s2_pay_ff.cy;
      h_pay_in.x2 = s2_ctl_ff.hold ? s2_pay_ff.x2 : sq_x;
      h_pay_in.y2 = s2_ctl_ff.hold ? s2_pay_ff.y2 : sq_y;
      h_pay_in.w = s2_ctl_ff.hold ? s2_pay_ff.w : sq_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff <= '0;
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         h_ctl_ff <= '0;
         out_valid_ff <= 1'b0;
         issue_tag_ff <= 2'd0;
         retire_tag_ff <= 2'd0;
      end else begin
         s0_ctl_ff <= s0_ctl_in;
         s1_ctl_ff <= s0_ctl_ff;
         s2_ctl_ff <= s1_ctl_ff;
         h_ctl_ff <= s2_ctl_ff;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (b_take) begin
            issue_tag_ff <= issue_tag_ff + 2'd1;
         end
         if (emit) begin
            retire_tag_ff <= retire_tag_ff + 2'd1;
         end
      end
      s0_pay_ff <= s0_pay_in;
      s0_x_ff <= s0_x_in;
      s0_y_ff <= s0_y_in;
      s1_pay_ff <= s0_pay_ff;
      mx_ff <= mbe_pkg::mag48(s0_x_ff);
      my_ff <= mbe_pkg::mag48(s0_y_ff);
      mz_ff <= mbe_pkg::mag48(z);
      s2_pay_ff <= s1_pay_ff;
      h_pay_ff <= h_pay_in;
      if (emit) begin
         out_count_ff <= h_ctl_ff.count;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_iteration_count = out_count_ff;

endmodule

[hw/rtl/mbe_csr.sv]
module mbe_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [4:0] csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready,
   output mbe_pkg::cfg_type cfg
);

   mbe_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0] sel;

   assign sel = csr_paddr[4:3];
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (sel)
            mbe_pkg::REG_ORIGIN_X: cfg_in.origin_x = csr_pwdata[47:0];
            mbe_pkg::REG_ORIGIN_Y: cfg_in.origin_y = csr_pwdata[47:0];
            mbe_pkg::REG_PIXEL_STEP: cfg_in.pixel_step = csr_pwdata[40:0];
            mbe_pkg::REG_MAX_ITERATIONS: cfg_in.max_iterations = csr_pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (sel)
         mbe_pkg::REG_ORIGIN_X: csr_prdata = {16'd0, cfg_ff.origin_x};
         mbe_pkg::REG_ORIGIN_Y: csr_prdata = {16'd0, cfg_ff.origin_y};
         mbe_pkg::REG_PIXEL_STEP: csr_prdata = {23'd0, cfg_ff.pixel_step};
         mbe_pkg::REG_MAX_ITERATIONS: csr_prdata = {48'd0, cfg_ff.max_iterations};
         default: csr_prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x <= mbe_pkg::RESET_ORIGIN_X;
         cfg_ff.origin_y <= mbe_pkg::RESET_ORIGIN_Y;
         cfg_ff.pixel_step <= mbe_pkg::RESET_PIXEL_STEP;
         cfg_ff.max_iterations <= mbe_pkg::RESET_MAX_ITERATIONS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/mbe_coord.sv]
module mbe_coord (
   input  logic clock,
   input  logic reset,
   input  mbe_pkg::cfg_type cfg,
   input  logic in_valid,
   output logic in_ready,
   input  logic [mbe_pkg::COORD_WIDTH-1:0] in_column,
   input  logic [mbe_pkg::COORD_WIDTH-1:0] in_row,
   output logic out_valid,
   input  logic out_take,
   output logic signed [mbe_pkg::VAL_WIDTH-1:0] out_cx,
   output logic signed [mbe_pkg::VAL_WIDTH-1:0] out_cy
);

   localparam int PW = mbe_pkg::PROD_WIDTH;

   logic a_valid_ff, b_valid_ff;
   logic [PW-1:0] px_ff, py_ff, px_in, py_in;
   logic signed [mbe_pkg::VAL_WIDTH-1:0] cx_ff, cy_ff, cx_in, cy_in;
   logic a_adv, b_adv;

   assign b_adv = !b_valid_ff || out_take;
   assign a_adv = !a_valid_ff || b_adv;
   assign in_ready = a_adv;
   assign out_valid = b_valid_ff;
   assign out_cx = cx_ff;
   assign out_cy = cy_ff;

   always_comb begin
      px_in = PW'(in_column) * PW'(cfg.pixel_step);
      py_in = PW'(in_row) * PW'(cfg.pixel_step);
      cx_in = mbe_pkg::sat48(56'(cfg.origin_x) + $signed(56'(px_ff)));
      cy_in = mbe_pkg::sat48(56'(cfg.origin_y) + $signed(56'(py_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_adv) begin
            a_valid_ff <= in_valid;
         end
         if (b_adv) begin
            b_valid_ff <= a_valid_ff;
         end
      end
      if (a_adv) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
      if (b_adv) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
      end
   end

endmodule

[hw/rtl/mbe_square.sv]
module mbe_square (
   input  logic clock,
   input  logic [mbe_pkg::VAL_WIDTH-1:0] mag,
   output logic [mbe_pkg::VAL_WIDTH-1:0] sq
);

   logic [63:0] p0_ff, p0_in;
   logic [47:0] mid_ff, mid_in;
   logic [31:0] p2_ff, p2_in;
   logic [95:0] full;
   logic [95:0] shifted;

   always_comb begin
      p0_in = 64'(mag[31:0]) * 64'(mag[31:0]);
      mid_in = 48'(mag[31:0]) * 48'(mag[47:32]);
      p2_in = 32'(mag[47:32]) * 32'(mag[47:32]);
      full = {p2_ff, 64'd0} + (96'(mid_ff) << 33) + 96'(p0_ff);
      shifted = full >> mbe_pkg::FRACTION_BITS;
      if (shifted > 96'(mbe_pkg::VAL_MAX)) begin
         sq = mbe_pkg::VAL_MAX;
      end else begin
         sq = shifted[mbe_pkg::VAL_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      p0_ff <= p0_in;
      mid_ff <= mid_in;
      p2_ff <= p2_in;
   end

endmodule

[dv/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint TOP = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint BOT = -TOP - 1;
   localparam longint ONE = 64'sd1 << mbe_pkg::FRACTION_BITS;
   localparam int STALL_LIMIT = 1000000;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS = 31;

   typedef enum logic {OP_PIXEL, OP_WRITE} op_type;

   typedef struct {
      op_type op;
      logic [1:0] index;
      longint value;
      logic [11:0] column;
      logic [11:0] row;
      bit fixed;
      int count;
   } stim_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [11:0] req_column;
   logic [11:0] req_row;
   logic rsp_valid;
   logic rsp_ready;
   logic [15:0] rsp_iteration_count;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [4:0] csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic csr_pready;

   logic signed [mbe_pkg::VAL_WIDTH-1:0] origin_re;
   logic signed [mbe_pkg::VAL_WIDTH-1:0] origin_im;
   logic [mbe_pkg::STEP_WIDTH-1:0] step;
   logic [mbe_pkg::COUNT_WIDTH-1:0] limit;

   logic [mbe_pkg::COUNT_WIDTH-1:0] counts_due[$];
   stim_type stimulus[$];
   int errors = 0;
   int pixels_sent = 0;
   int counts_seen = 0;
   int transactions = 0;
   bit eager = 0;

   mandelbrot_escape_time_pixel i_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp(longint v);
      if (v > TOP) return TOP;
      if (v < BOT) return BOT;
      return v;
   endfunction

   function automatic longint square(longint s);
      logic [mbe_pkg::VAL_WIDTH-1:0] m;
      logic [95:0] p;
      m = mbe_pkg::VAL_WIDTH'(s < 0 ? -s : s);
      p = (96'(m) * 96'(m)) >> mbe_pkg::FRACTION_BITS;
      if (p > 96'(TOP)) return TOP;
      return longint'(p);
   endfunction

   function automatic logic [mbe_pkg::COUNT_WIDTH-1:0] escape_count(logic [11:0] column,
                                                                    logic [11:0] row);
      longint cx, cy, x, y, x2, y2, w, four;
      int n;
      cx = clamp(longint'(origin_re) + longint'(column) * longint'({23'b0, step}));
      cy = clamp(longint'(origin_im) + longint'(row) * longint'({23'b0, step}));
      four = 64'sd4 << mbe_pkg::FRACTION_BITS;
      x2 = 0;
      y2 = 0;
      w = 0;
      n = 0;
      while (x2 + y2 <= four && n < int'(limit)) begin
         x = clamp(x2 - y2 + cx);
         y = clamp(w - (x2 + y2) + cy);
         x2 = square(x);
         y2 = square(y);
         w = square(clamp(x + y));
         n++;
      end
      return mbe_pkg::COUNT_WIDTH'(n);
   endfunction

   function automatic int gap();
      int r;
      r = $urandom_range(0, 99);
      if (eager || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic wait_idle();
      while (counts_due.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_register(logic [1:0] index, longint value);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_penable = 0;
      csr_paddr = {index, 3'b000};
      csr_pwdata = 64'(value);
      @(negedge clock);
      csr_penable = 1;
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      case (index)
         mbe_pkg::REG_ORIGIN_X: origin_re = mbe_pkg::VAL_WIDTH'(value);
         mbe_pkg::REG_ORIGIN_Y: origin_im = mbe_pkg::VAL_WIDTH'(value);
         mbe_pkg::REG_PIXEL_STEP: step = mbe_pkg::STEP_WIDTH'(value);
         mbe_pkg::REG_MAX_ITERATIONS: limit = mbe_pkg::COUNT_WIDTH'(value);
         default: ;
      endcase
   endtask

   task automatic send_pixel(logic [11:0] column, logic [11:0] row, bit fixed, int count);
      logic [mbe_pkg::COUNT_WIDTH-1:0] due;
      int idle;
      idle = gap();
      if (idle != 0) begin
         req_valid = 0;
         repeat (idle) @(negedge clock);
      end
      req_valid = 1;
      req_column = column;
      req_row = row;
      do @(posedge clock); while (!req_ready);
      due = escape_count(column, row);
      if (fixed && due != mbe_pkg::COUNT_WIDTH'(count)) begin
         $error("iteration_count: expected %0d, predicted %0d", count, due);
         errors++;
      end
      counts_due.push_back(fixed ? mbe_pkg::COUNT_WIDTH'(count) : due);
      pixels_sent++;
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic add_write(logic [1:0] index, longint value);
      stim_type s;
      s = '{OP_WRITE, index, value, 0, 0, 0, 0};
      stimulus.push_back(s);
   endtask

   task automatic add_pixel(logic [11:0] column, logic [11:0] row, bit fixed, int count);
      stim_type s;
      s = '{OP_PIXEL, 0, 0, column, row, fixed, count};
      stimulus.push_back(s);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (counts_due.size() == 0) begin
            $error("iteration_count: no transaction expected, actual %0d",
                   rsp_iteration_count);
            errors++;
         end else if (counts_due[0] != rsp_iteration_count) begin
            $error("iteration_count: expected %0d, actual %0d", counts_due[0],
                   rsp_iteration_count);
            errors++;
            void'(counts_due.pop_front());
         end else begin
            void'(counts_due.pop_front());
         end
         counts_seen++;
      end
      if (!reset && ((rsp_valid && rsp_ready) || (req_valid && req_ready))) begin
         transactions++;
      end
   end

   initial begin
      bit held;
      int r;
      held = 0;
      rsp_ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!held && counts_seen >= 40) begin
            held = 1;
            rsp_ready = 0;
            repeat (2500) @(negedge clock);
         end
         r = $urandom_range(0, 99);
         if (eager || r < 60) begin
            rsp_ready = 1;
         end else if (r < 93) begin
            rsp_ready = 0;
            repeat ($urandom_range(0, 3)) @(negedge clock);
         end else begin
            rsp_ready = 0;
            repeat ($urandom_range(10, 60)) @(negedge clock);
         end
      end
   end

   initial begin
      int last, idle;
      last = 0;
      idle = 0;
      forever begin
         @(posedge clock);
         if (transactions != last) begin
            last = transactions;
            idle = 0;
         end else if (!reset) begin
            idle++;
            if (idle >= STALL_LIMIT) begin
               $display("status: fail");
               $finish;
            end
         end
      end
   end

   initial begin
      int kind;
      reset = 1;
      req_valid = 0;
      req_column = 0;
      req_row = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      origin_re = mbe_pkg::RESET_ORIGIN_X;
      origin_im = mbe_pkg::RESET_ORIGIN_Y;
      step = mbe_pkg::RESET_PIXEL_STEP;
      limit = mbe_pkg::RESET_MAX_ITERATIONS;

      add_pixel(0, 0, 0, 0);
      add_pixel(4095, 4095, 0, 0);
      add_pixel(2048, 1, 0, 0);
      add_write(mbe_pkg::REG_MAX_ITERATIONS, 0);
      add_pixel(4095, 0, 1, 0);
      add_pixel(0, 4095, 1, 0);
      add_write(mbe_pkg::REG_MAX_ITERATIONS, 65535);
      add_write(mbe_pkg::REG_ORIGIN_X, TOP);
      add_pixel(0, 0, 1, 1);
      add_write(mbe_pkg::REG_ORIGIN_X, BOT);
      add_pixel(5, 5, 1, 1);
      add_write(mbe_pkg::REG_ORIGIN_X, TOP - 10);
      add_write(mbe_pkg::REG_PIXEL_STEP, ONE);
      add_pixel(4095, 0, 1, 1);
      add_write(mbe_pkg::REG_ORIGIN_X, 0);
      add_write(mbe_pkg::REG_ORIGIN_Y, BOT);
      add_pixel(0, 4095, 0, 0);
      add_write(mbe_pkg::REG_ORIGIN_Y, 0);
      add_write(mbe_pkg::REG_PIXEL_STEP, 0);
      add_write(mbe_pkg::REG_MAX_ITERATIONS, 50);
      add_pixel(4095, 4095, 1, 50);
      add_write(mbe_pkg::REG_ORIGIN_X, -2 * ONE);
      add_write(mbe_pkg::REG_ORIGIN_Y, -ONE);
      add_write(mbe_pkg::REG_PIXEL_STEP, 64'sd1 << 29);
      add_write(mbe_pkg::REG_MAX_ITERATIONS, 100);
      add_pixel(4095, 4095, 0, 0);
      add_pixel(2750, 2048, 0, 0);

      repeat (10) @(negedge clock);
      reset = 0;

      foreach (stimulus[i]) begin
         if (stimulus[i].op == OP_WRITE) begin
            wait_idle();
            write_register(stimulus[i].index, stimulus[i].value);
         end else begin
            send_pixel(stimulus[i].column, stimulus[i].row, stimulus[i].fixed,
                       stimulus[i].count);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         kind = $urandom_range(0, 9);
         eager = (p % 3 == 2);
         if (kind < 7) begin
            write_register(mbe_pkg::REG_ORIGIN_X,
                           -2 * ONE + (longint'($urandom_range(0, 1 << 20)) << 20));
            write_register(mbe_pkg::REG_ORIGIN_Y, -ONE - (ONE >> 2)
                           + (longint'($urandom_range(0, 1 << 20)) << 20));
            write_register(mbe_pkg::REG_PIXEL_STEP,
                           longint'($urandom_range(1 << 18, 1 << 20)) << 8);
            write_register(mbe_pkg::REG_MAX_ITERATIONS, $urandom_range(1, 120));
         end else begin
            write_register(mbe_pkg::REG_ORIGIN_X, {$urandom, $urandom});
            write_register(mbe_pkg::REG_ORIGIN_Y, {$urandom, $urandom});
            write_register(mbe_pkg::REG_PIXEL_STEP, {$urandom, $urandom});
            write_register(mbe_pkg::REG_MAX_ITERATIONS, $urandom_range(0, 65535));
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), 0, 0);
         end
      end

      while (counts_due.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      $display("Sent %0d pixels over %0d random windows plus directed corners;",
               pixels_sent, RANDOM_PHASES);
      $display("checked %0d iteration counts with one long output stall.", counts_seen);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
